// File: hdl/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ges_pkg.sv
// Types, constants and fixed point helpers of the Gaussian elimination solver.
// Depends on nothing; used by ges_div and gaussian_elimination_solver.
package ges_pkg;

  localparam int MAX_N     = 16;
  localparam int FRAC_BITS = 16;
  localparam int STRIDE    = MAX_N + 1;
  localparam int DEPTH     = MAX_N * STRIDE;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(MAX_N + 1);
  localparam int RW        = $clog2(MAX_N);
  localparam int NW        = 32 + FRAC_BITS;

  typedef struct packed {
    logic [3:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [3:0]         index;
    logic signed [31:0] solution_value;
    logic               status;
    logic               end_of_run;
  } out_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK,
    S_SWP_RDA, S_SWP_RDB, S_SWP_WA, S_SWP_WB,
    S_ELIM_RD, S_ELIM_DIV, S_ELIM_DWAIT,
    S_UPD_RDA, S_UPD_RDB, S_UPD_MUL, S_UPD_WR, S_ZERO,
    S_BK_INIT, S_BK_RDA, S_BK_MUL, S_BK_SH, S_BK_ACC,
    S_BK_RHS, S_BK_PIV, S_BK_DIV, S_BK_DWAIT, S_SING
  } state_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) r = 32'sh7fffffff;
    else if (v < -33'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Scales a full product back to fixed point, truncating toward zero.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [63:0] s;
    logic signed [31:0] r;
    adj = p + (p[63] ? 64'sd0 + ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0);
    s = adj >>> FRAC_BITS;
    if (s > 64'sd2147483647) r = 32'sh7fffffff;
    else if (s < -64'sd2147483648) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

endpackage

// File: hdl/gaussian_elimination_solver.sv
// Top level: entry load, matrix memory, solve sequencer and shared multiplier.
// Depends on ges_pkg, ges_div and assert_macros.svh.
//
//  channel  | ports                           | transfer
//  input    | start, busy, item               | start high, busy low
//  result   | result_valid, result            | one cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_data  | valid and ready high
//
// Loading takes one entry per cycle while busy is low. Solving runs through one shared
// multiplier and one bit-serial divider; a row update divides once and
// then reads, multiplies and writes each column, a swap exchanges each
// column of the two rows, and busy is high from the last entry
// to the final result. Reset is synchronous; the memory needs no clearing.
`include "assert_macros.svh"

module gaussian_elimination_solver (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ges_pkg::in_t   item,
  output logic           result_valid,
  output ges_pkg::out_t  result,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [4:0]     cfg_data
);

  localparam int AW = ges_pkg::AW;
  localparam int CW = ges_pkg::CW;
  localparam int RW = ges_pkg::RW;

  ges_pkg::state_t state, state_next;

  logic [4:0]          size_in_use;
  logic [CW-1:0]       n, nm1, i, j, k;
  logic [CW-1:0]       n_next, nm1_next, i_next, j_next, k_next;
  logic signed [31:0]  mem [ges_pkg::DEPTH];
  logic signed [31:0]  sol [ges_pkg::MAX_N];
  logic signed [31:0]  mem_q, sol_q;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                we, sol_we;
  logic signed [31:0]  wr_data;
  logic signed [31:0]  piv, tmp, f, ajk, mq, sum, numv;
  logic signed [63:0]  prod;
  logic                out_fire, out_sing;
  ges_pkg::div_req_t   div_req;
  ges_pkg::div_rsp_t   div_rsp;
  logic [CW-1:0]       n_eff;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(32'(r) * ges_pkg::STRIDE + 32'(c));
  endfunction

  assign busy      = (state != ges_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign n_eff     = (size_in_use == 5'd0) ? CW'(1) :
                     (32'(size_in_use) > ges_pkg::MAX_N) ? CW'(ges_pkg::MAX_N) :
                     CW'(size_in_use);

  ges_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ges_pkg::S_IDLE;
      size_in_use  <= 5'd16;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= out_fire;
      if (cfg_valid && cfg_ready) begin
        size_in_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    nm1 <= nm1_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    mem_q <= mem[rd_addr];
    sol_q <= sol[j[RW-1:0]];
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (sol_we) begin
      sol[i[RW-1:0]] <= div_rsp.quot;
    end
    unique case (state)
      ges_pkg::S_PIV_CHK:  piv <= mem_q;
      ges_pkg::S_SWP_RDB:  tmp <= mem_q;
      ges_pkg::S_UPD_RDB:  prod <= 64'(f) * 64'(mem_q);
      ges_pkg::S_UPD_MUL: begin
        mq  <= ges_pkg::qscale(prod);
        ajk <= mem_q;
      end
      ges_pkg::S_BK_INIT:  sum <= '0;
      ges_pkg::S_BK_MUL:   prod <= 64'(mem_q) * 64'(sol_q);
      ges_pkg::S_BK_SH:    mq <= ges_pkg::qscale(prod);
      ges_pkg::S_BK_ACC:   sum <= ges_pkg::sat33(33'(sum) + 33'(mq));
      ges_pkg::S_BK_PIV:   numv <= ges_pkg::sat33(33'(mem_q) - 33'(sum));
      default: begin
      end
    endcase
    if (state == ges_pkg::S_ELIM_DWAIT && div_rsp.done) begin
      f <= div_rsp.quot;
    end
    if (out_fire) begin
      result.index          <= out_sing ? 4'd0 : i[3:0];
      result.solution_value <= out_sing ? 32'sd0 : div_rsp.quot;
      result.status         <= out_sing;
      result.end_of_run     <= out_sing || (i == '0);
    end
  end

  always_comb begin
    state_next    = state;
    n_next        = n;
    nm1_next      = nm1;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    rd_addr       = cell_addr(i, i);
    we            = 1'b0;
    wr_addr       = cell_addr(i, k);
    wr_data       = mem_q;
    sol_we        = 1'b0;
    out_fire      = 1'b0;
    out_sing      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = mem_q;
    div_req.den   = piv;
    unique case (state)
      ges_pkg::S_IDLE: begin
        if (start) begin
          if (32'(item.row) < ges_pkg::MAX_N && 32'(item.col) <= ges_pkg::MAX_N) begin
            we      = 1'b1;
            wr_addr = cell_addr(CW'(item.row), CW'(item.col));
            wr_data = item.value;
          end
          if (item.last) begin
            n_next     = n_eff;
            nm1_next   = n_eff - 1'b1;
            i_next     = '0;
            state_next = ges_pkg::S_PIV_RD;
          end
        end
      end
      ges_pkg::S_PIV_RD: begin
        rd_addr    = cell_addr(i, i);
        state_next = ges_pkg::S_PIV_CHK;
      end
      ges_pkg::S_PIV_CHK: begin
        j_next = i + 1'b1;
        if (mem_q != 0) begin
          if (i == nm1) begin
            i_next     = nm1;
            state_next = ges_pkg::S_BK_INIT;
          end else begin
            state_next = ges_pkg::S_ELIM_RD;
          end
        end else if (i == nm1) begin
          state_next = ges_pkg::S_SING;
        end else begin
          state_next = ges_pkg::S_SRCH_RD;
        end
      end
      ges_pkg::S_SRCH_RD: begin
        rd_addr    = cell_addr(j, i);
        state_next = ges_pkg::S_SRCH_CHK;
      end
      ges_pkg::S_SRCH_CHK: begin
        if (mem_q != 0) begin
          k_next     = '0;
          state_next = ges_pkg::S_SWP_RDA;
        end else if (j == nm1) begin
          state_next = ges_pkg::S_SING;
        end else begin
          j_next     = j + 1'b1;
          state_next = ges_pkg::S_SRCH_RD;
        end
      end
      ges_pkg::S_SWP_RDA: begin
        rd_addr    = cell_addr(i, k);
        state_next = ges_pkg::S_SWP_RDB;
      end
      ges_pkg::S_SWP_RDB: begin
        rd_addr    = cell_addr(j, k);
        state_next = ges_pkg::S_SWP_WA;
      end
      ges_pkg::S_SWP_WA: begin
        we         = 1'b1;
        wr_addr    = cell_addr(i, k);
        wr_data    = mem_q;
        state_next = ges_pkg::S_SWP_WB;
      end
      ges_pkg::S_SWP_WB: begin
        we      = 1'b1;
        wr_addr = cell_addr(j, k);
        wr_data = tmp;
        if (k == n) begin
          state_next = ges_pkg::S_PIV_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = ges_pkg::S_SWP_RDA;
        end
      end
      ges_pkg::S_ELIM_RD: begin
        rd_addr    = cell_addr(j, i);
        state_next = ges_pkg::S_ELIM_DIV;
      end
      ges_pkg::S_ELIM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = mem_q;
        div_req.den   = piv;
        state_next    = ges_pkg::S_ELIM_DWAIT;
      end
      ges_pkg::S_ELIM_DWAIT: begin
        if (div_rsp.done) begin
          k_next     = i + 1'b1;
          state_next = ges_pkg::S_UPD_RDA;
        end
      end
      ges_pkg::S_UPD_RDA: begin
        rd_addr    = cell_addr(i, k);
        state_next = ges_pkg::S_UPD_RDB;
      end
      ges_pkg::S_UPD_RDB: begin
        rd_addr    = cell_addr(j, k);
        state_next = ges_pkg::S_UPD_MUL;
      end
      ges_pkg::S_UPD_MUL: begin
        state_next = ges_pkg::S_UPD_WR;
      end
      ges_pkg::S_UPD_WR: begin
        we      = 1'b1;
        wr_addr = cell_addr(j, k);
        wr_data = ges_pkg::sat33(33'(ajk) - 33'(mq));
        if (k == n) begin
          state_next = ges_pkg::S_ZERO;
        end else begin
          k_next     = k + 1'b1;
          state_next = ges_pkg::S_UPD_RDA;
        end
      end
      ges_pkg::S_ZERO: begin
        we      = 1'b1;
        wr_addr = cell_addr(j, i);
        wr_data = '0;
        if (j == nm1) begin
          i_next     = i + 1'b1;
          state_next = ges_pkg::S_PIV_RD;
        end else begin
          j_next     = j + 1'b1;
          state_next = ges_pkg::S_ELIM_RD;
        end
      end
      ges_pkg::S_BK_INIT: begin
        j_next     = i + 1'b1;
        state_next = (i == nm1) ? ges_pkg::S_BK_RHS : ges_pkg::S_BK_RDA;
      end
      ges_pkg::S_BK_RDA: begin
        rd_addr    = cell_addr(i, j);
        state_next = ges_pkg::S_BK_MUL;
      end
      ges_pkg::S_BK_MUL: begin
        state_next = ges_pkg::S_BK_SH;
      end
      ges_pkg::S_BK_SH: begin
        state_next = ges_pkg::S_BK_ACC;
      end
      ges_pkg::S_BK_ACC: begin
        if (j == nm1) begin
          state_next = ges_pkg::S_BK_RHS;
        end else begin
          j_next     = j + 1'b1;
          state_next = ges_pkg::S_BK_RDA;
        end
      end
      ges_pkg::S_BK_RHS: begin
        rd_addr    = cell_addr(i, n);
        state_next = ges_pkg::S_BK_PIV;
      end
      ges_pkg::S_BK_PIV: begin
        rd_addr    = cell_addr(i, i);
        state_next = ges_pkg::S_BK_DIV;
      end
      ges_pkg::S_BK_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = numv;
        div_req.den   = mem_q;
        state_next    = ges_pkg::S_BK_DWAIT;
      end
      ges_pkg::S_BK_DWAIT: begin
        if (div_rsp.done) begin
          sol_we   = 1'b1;
          out_fire = 1'b1;
          if (i == '0) begin
            state_next = ges_pkg::S_IDLE;
          end else begin
            i_next     = i - 1'b1;
            state_next = ges_pkg::S_BK_INIT;
          end
        end
      end
      ges_pkg::S_SING: begin
        out_fire   = 1'b1;
        out_sing   = 1'b1;
        state_next = ges_pkg::S_IDLE;
      end
      default: begin
        state_next = ges_pkg::S_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_eor_idle, clk, rst,
    !(result_valid && result.end_of_run) || (state == ges_pkg::S_IDLE), "end of run while busy")
  `ASSERT_ALWAYS(a_mid_result, clk, rst,
    !(result_valid && !result.end_of_run) || (state == ges_pkg::S_BK_INIT), "result out of step")
  `ASSERT_ALWAYS(a_div_wait, clk, rst,
    !div_rsp.done || (state == ges_pkg::S_ELIM_DWAIT) || (state == ges_pkg::S_BK_DWAIT),
    "quotient with no waiter")
  `ASSERT_ALWAYS(a_sing_eor, clk, rst,
    !(result_valid && result.status) || result.end_of_run, "singular result not final")
  `ASSERT_NEXT(a_load_idle, clk, rst, start && !busy && !item.last, !busy,
    "busy after a plain entry")

endmodule

// File: hdl/ges_div.sv
// Iterative restoring divider for fixed point quotients, one bit per cycle.
// Depends on ges_pkg for widths and the request and response types.
module ges_div (
  input  logic              clk,
  input  logic              rst,
  input  ges_pkg::div_req_t req,
  output ges_pkg::div_rsp_t rsp
);

  localparam int CTW = $clog2(ges_pkg::NW + 1);

  logic                   run;
  logic                   fin;
  logic [CTW-1:0]         cnt;
  logic [ges_pkg::NW-1:0] nq;
  logic [31:0]            rem;
  logic [31:0]            dmag;
  logic                   neg;
  logic [32:0]            remsh;
  logic                   ge;
  logic [31:0]            amag;
  logic signed [31:0]     qsat;

  assign amag  = req.num[31] ? 32'(-req.num) : 32'(req.num);
  assign remsh = {rem, nq[ges_pkg::NW-1]};
  assign ge    = remsh >= {1'b0, dmag};

  always_comb begin
    if (!neg) begin
      qsat = (nq[ges_pkg::NW-1:31] != '0) ? 32'sh7fffffff : $signed(nq[31:0]);
    end else if ((nq[ges_pkg::NW-1:32] != '0) || (nq[31] && (nq[30:0] != '0))) begin
      qsat = 32'sh80000000;
    end else begin
      qsat = $signed(-nq[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= fin;
      fin      <= 1'b0;
      if (fin) begin
        rsp.quot <= qsat;
      end
      if (req.start) begin
        run <= 1'b1;
        cnt <= CTW'(ges_pkg::NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CTW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      nq   <= {amag, {ges_pkg::FRAC_BITS{1'b0}}};
      dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
      rem  <= '0;
      neg  <= req.num[31] ^ req.den[31];
    end else if (run) begin
      rem <= ge ? 32'(remsh - {1'b0, dmag}) : remsh[31:0];
      nq  <= {nq[ges_pkg::NW-2:0], ge};
    end
  end

endmodule

// File: verif/gaussian_elimination_solver_test.sv
// Self-checking testbench of the Gaussian elimination solver: directed systems
// and random loads, checked by an in-bench fixed point solver or a set result.
// Depends on ges_pkg and the gaussian_elimination_solver RTL.
`timescale 1ns / 1ps

module gaussian_elimination_solver_test;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic SOLVE_OK = 1'b0;
  localparam logic SOLVE_SINGULAR = 1'b1;

  typedef struct {
    logic is_cfg;
    logic [4:0] cfg;
    ges_pkg::in_t entry;
    logic typed;
    ges_pkg::out_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ges_pkg::in_t item = '0;
  logic result_valid;
  ges_pkg::out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  logic signed [31:0] mat[ges_pkg::MAX_N][ges_pkg::STRIDE];
  logic signed [31:0] sol[ges_pkg::MAX_N];
  bit loaded[ges_pkg::MAX_N][ges_pkg::STRIDE];
  int eq_count = ges_pkg::MAX_N;
  ges_pkg::out_t pending_solutions[$];
  int failures = 0;
  int cycles = 0;
  int items_sent = 0;

  gaussian_elimination_solver u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(p / 65536);
  endfunction

  function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] d);
    longint num;
    num = longint'(a) * 65536;
    return sat(num / longint'(d));
  endfunction

  function automatic bit eliminate(int n);
    logic signed [31:0] t, f;
    logic signed [31:0] acc;
    for (int i = 0; i < n - 1; i++) begin
      if (mat[i][i] == 0) begin
        for (int j = i + 1; j < n; j++) begin
          if (mat[j][i] != 0) begin
            for (int k = 0; k <= n; k++) begin
              t = mat[i][k];
              mat[i][k] = mat[j][k];
              mat[j][k] = t;
            end
            break;
          end
        end
      end
      if (mat[i][i] == 0) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        f = fx_div(mat[j][i], mat[i][i]);
        for (int k = i + 1; k <= n; k++) mat[j][k] = sat(longint'(mat[j][k]) -
            longint'(fx_mul(f, mat[i][k])));
        mat[j][i] = 0;
      end
    end
    if (mat[n-1][n-1] == 0) return 1'b0;
    for (int i = n - 1; i >= 0; i--) begin
      acc = 0;
      for (int j = i + 1; j < n; j++) acc = sat(longint'(acc) + longint'(fx_mul(mat[i][j], sol[j])));
      sol[i] = fx_div(sat(longint'(mat[i][n]) - longint'(acc)), mat[i][i]);
    end
    return 1'b1;
  endfunction

  function automatic void predict_solution(ges_pkg::in_t e);
    ges_pkg::out_t r;
    if (e.row < ges_pkg::MAX_N && e.col <= ges_pkg::MAX_N) begin
      mat[e.row][e.col] = e.value;
      loaded[e.row][e.col] = 1'b1;
    end
    if (!e.last) return;
    if (!eliminate(eq_count)) begin
      r = '{index: 4'd0, solution_value: 32'sd0, status: SOLVE_SINGULAR, end_of_run: 1'b1};
      pending_solutions.push_back(r);
      return;
    end
    for (int i = eq_count - 1; i >= 0; i--) begin
      r = '{index: 4'(i), solution_value: sol[i], status: SOLVE_OK, end_of_run: i == 0};
      pending_solutions.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    ges_pkg::out_t w;
    if (!rst && result_valid) begin
      if (pending_solutions.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        failures++;
      end else begin
        w = pending_solutions.pop_front();
        if (result.index !== w.index) begin
          $display("%0t: index expected %0d actual %0d", $time, w.index, result.index);
          failures++;
        end
        if (result.solution_value !== w.solution_value) begin
          $display("%0t: value expected %h actual %h", $time, w.solution_value,
                   result.solution_value);
          failures++;
        end
        if (result.status !== w.status) begin
          $display("%0t: status expected %b actual %b", $time, w.status, result.status);
          failures++;
        end
        if (result.end_of_run !== w.end_of_run) begin
          $display("%0t: end_of_run expected %b actual %b", $time, w.end_of_run,
                   result.end_of_run);
          failures++;
        end
      end
    end
  end

  task automatic send(ges_pkg::in_t e, logic typed = 1'b0, ges_pkg::out_t want = '0);
    int gap;
    int base;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= e;
    do @(posedge clk); while (busy);
    items_sent++;
    if (typed) begin
      base = pending_solutions.size();
      predict_solution(e);
      while (pending_solutions.size() > base) void'(pending_solutions.pop_back());
      pending_solutions.push_back(want);
    end else begin
      predict_solution(e);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_solutions.size() != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(logic [4:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eq_count = (v == 0) ? 1 : (v > ges_pkg::MAX_N) ? ges_pkg::MAX_N : v;
  endtask

  function automatic step_t entry(int r, int c, logic [31:0] v, logic l);
    step_t s;
    s = '{is_cfg: 1'b0, cfg: '0, entry: '{row: 4'(r), col: 5'(c), value: v, last: l},
          typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t checked(int r, int c, logic [31:0] v, logic l, logic [31:0] x,
                                    logic st);
    step_t s;
    s = entry(r, c, v, l);
    s.typed = 1'b1;
    s.want = '{index: 4'd0, solution_value: st ? 32'sd0 : x, status: st, end_of_run: 1'b1};
    return s;
  endfunction

  function automatic step_t size_step(logic [4:0] v);
    step_t s;
    s = entry(0, 0, 0, 0);
    s.is_cfg = 1'b1;
    s.cfg = v;
    return s;
  endfunction

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
    endcase
  endfunction

  initial begin
    step_t directed[$];
    int order[$];
    int n, pick, mid;
    logic [4:0] v;
    ges_pkg::in_t e;

    directed.push_back(size_step(5'd1));
    directed.push_back(entry(0, 0, 32'h10000, 0));
    directed.push_back(checked(0, 1, 32'h20000, 1, 32'h20000, SOLVE_OK));
    directed.push_back(checked(0, 1, 32'h7fffffff, 1, 32'h7fffffff, SOLVE_OK));
    directed.push_back(checked(0, 1, 32'h80000000, 1, 32'h80000000, SOLVE_OK));
    directed.push_back(checked(0, 0, 32'h0, 1, 0, SOLVE_SINGULAR));
    directed.push_back(entry(0, 0, 32'h10000, 0));
    directed.push_back(checked(15, 31, 32'hffffffff, 1, 32'h80000000, SOLVE_OK));
    directed.push_back(entry(0, 0, 32'h8000, 0));
    directed.push_back(checked(0, 1, 32'h7fffffff, 1, 32'h7fffffff, SOLVE_OK));
    directed.push_back(size_step(5'd0));
    directed.push_back(checked(3, 20, 32'h12345678, 1, 32'h7fffffff, SOLVE_OK));
    directed.push_back(entry(15, 16, 32'h0, 0));
    directed.push_back(size_step(5'd2));
    directed.push_back(entry(0, 0, 32'h0, 0));
    directed.push_back(entry(0, 1, 32'h10000, 0));
    directed.push_back(entry(0, 2, 32'h30000, 0));
    directed.push_back(entry(1, 0, 32'h10000, 0));
    directed.push_back(entry(1, 1, 32'h10000, 0));
    directed.push_back(entry(1, 2, 32'h50000, 1));
    directed.push_back(entry(1, 2, 32'hfffe0000, 1));
    directed.push_back(entry(0, 0, 32'h10000, 0));
    directed.push_back(entry(0, 1, 32'h10000, 0));
    directed.push_back(entry(1, 0, 32'h10000, 0));
    directed.push_back(checked(1, 1, 32'h10000, 1, 0, SOLVE_SINGULAR));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_size(directed[i].cfg);
      else send(directed[i].entry, directed[i].typed, directed[i].want);
    end

    write_size(5'd31);
    while (items_sent < 300) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 99);
        n = (pick < 90) ? $urandom_range(1, 4) : (pick < 93) ? ges_pkg::MAX_N :
            $urandom_range(5, 8);
        v = 5'(n);
        if (n == 1 && $urandom_range(0, 1)) v = 5'd0;
        if (n == ges_pkg::MAX_N && $urandom_range(0, 1)) v = 5'($urandom_range(17, 31));
        write_size(v);
      end else if ($urandom_range(0, 3) == 0) begin
        settle();
      end
      n = eq_count;
      order.delete();
      for (int k = 0; k < n * (n + 1); k++) order.push_back(k);
      order.shuffle();
      mid = $urandom_range(0, order.size() - 1);
      foreach (order[k]) begin
        if ($urandom_range(0, 9) == 0) begin
          e = '{row: 4'($urandom_range(0, 15)), col: 5'($urandom_range(17, 31)),
                value: $urandom(), last: 1'b0};
          send(e);
        end
        e = '{row: 4'(order[k] / (n + 1)), col: 5'(order[k] % (n + 1)),
              value: draw_value(), last: k == order.size() - 1};
        if (k == mid && $urandom_range(0, 4) == 0) begin
          e.last = 1'b1;
          for (int r = 0; r < n; r++)
            for (int c = 0; c <= n; c++)
              if (!loaded[r][c] && !(r == e.row && c == e.col)) e.last = 1'b0;
        end
        send(e);
      end
      if ($urandom_range(0, 4) == 0) begin
        e = '{row: 4'($urandom_range(0, 15)), col: 5'($urandom_range(17, 31)),
              value: $urandom(), last: 1'b1};
        send(e);
      end
    end

    start <= 1'b0;
    wait (pending_solutions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
